/* hw/rtl/cbq_pkg.sv */
`default_nettype none
// ----------------------------------------------------------------------------
// Cascaded biquad package
// Shared types and constants for the cascaded Q15 biquad filter.
// ----------------------------------------------------------------------------
package cbq_pkg;

	localparam int DATA_W     = 16;
	localparam int ACC_W      = 32;
	localparam int ACT_W      = 2;
	localparam int CFG_IDX_W  = 3;
	localparam int CFG_DATA_W = 48;
	localparam int FWD_W      = 48;
	localparam int FB_W       = 32;

	// configuration register indexes
	localparam logic [CFG_IDX_W-1:0] REG_ACTIVE = 3'd0;
	localparam logic [CFG_IDX_W-1:0] REG_S0_FWD = 3'd1;
	localparam logic [CFG_IDX_W-1:0] REG_S0_FB  = 3'd2;

	// history slots within one stage
	localparam logic [1:0] SLOT_X1 = 2'd0;
	localparam logic [1:0] SLOT_X2 = 2'd1;
	localparam logic [1:0] SLOT_Y1 = 2'd2;
	localparam logic [1:0] SLOT_Y2 = 2'd3;

	typedef enum logic [1:0] {
		ST_IDLE,
		ST_RUN,
		ST_LAST,
		ST_HOLD
	} state_t;

	// multiply-accumulate steps of one stage, in issue order
	typedef enum logic [2:0] {
		OP_B0,
		OP_B1A,
		OP_B1B,
		OP_B2,
		OP_A1A,
		OP_A1B,
		OP_A2
	} op_t;

	typedef struct packed {
		logic issue;
		logic first;
		logic neg;
	} mac_ctl_t;

	typedef struct packed {
		op_t  op;
		logic busy;
		logic wb;
		logic ld_out;
	} seq_t;

endpackage
`default_nettype wire

/* hw/rtl/cbq_mac.sv */
`default_nettype none
// ----------------------------------------------------------------------------
// Cascaded biquad shared MAC
// Registered Q15 multiply with doubling to Q31, then saturating accumulate.
// ----------------------------------------------------------------------------
module cbq_mac
	import cbq_pkg::*;
(
	input  wire logic                     clk,
	input  wire logic                     arst_n,
	input  wire mac_ctl_t                 ctl,
	input  wire logic signed [DATA_W-1:0] coef,
	input  wire logic signed [DATA_W-1:0] data,
	output logic signed [ACC_W-1:0]       acc_next
);

	logic signed [ACC_W-1:0] prod;
	logic signed [ACC_W-1:0] dbl;
	logic signed [ACC_W-1:0] p_s1;
	logic                    vld_s1;
	logic                    first_s1;
	logic                    neg_s1;
	logic signed [ACC_W-1:0] acc_q;
	logic signed [ACC_W-1:0] base;
	logic signed [ACC_W:0]   sum;

	always_comb begin
		prod = coef * data;
		// only full-scale negative squared overflows when doubled
		if (prod == 32'sh4000_0000) begin
			dbl = 32'sh7FFF_FFFF;
		end else begin
			dbl = prod <<< 1;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s1 <= 1'b0;
		end else begin
			vld_s1 <= ctl.issue;
		end
	end

	always_ff @(posedge clk) begin
		p_s1     <= dbl;
		first_s1 <= ctl.first;
		neg_s1   <= ctl.neg;
	end

	always_comb begin
		base = first_s1 ? '0 : acc_q;
		if (neg_s1) begin
			sum = {base[ACC_W-1], base} - {p_s1[ACC_W-1], p_s1};
		end else begin
			sum = {base[ACC_W-1], base} + {p_s1[ACC_W-1], p_s1};
		end
		if (sum[ACC_W] != sum[ACC_W-1]) begin
			acc_next = sum[ACC_W] ? {1'b1, {(ACC_W-1){1'b0}}} : {1'b0, {(ACC_W-1){1'b1}}};
		end else begin
			acc_next = sum[ACC_W-1:0];
		end
	end

	always_ff @(posedge clk) begin
		if (vld_s1) begin
			acc_q <= acc_next;
		end
	end

endmodule
`default_nettype wire

/* hw/rtl/cbq_ctrl.sv */
`default_nettype none
// ----------------------------------------------------------------------------
// Cascaded biquad sequencer
// Steps the shared MAC through seven operations per stage over the stages.
// ----------------------------------------------------------------------------
module cbq_ctrl
	import cbq_pkg::*;
#(
	parameter int SW = 2
)
(
	input  wire logic          clk,
	input  wire logic          arst_n,
	input  wire logic          start,
	input  wire logic [SW-1:0] last_stage,
	input  wire logic          out_free,
	output mac_ctl_t           mac_ctl,
	output seq_t               seq,
	output logic [SW-1:0]      stage
);

	state_t        state_q;
	state_t        state_d;
	op_t           op_q;
	op_t           op_d;
	logic [SW-1:0] stage_q;
	logic [SW-1:0] stage_d;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
			op_q    <= OP_B0;
			stage_q <= '0;
		end else begin
			state_q <= state_d;
			op_q    <= op_d;
			stage_q <= stage_d;
		end
	end

	always_comb begin
		state_d       = state_q;
		op_d          = op_q;
		stage_d       = stage_q;
		mac_ctl.issue = 1'b0;
		mac_ctl.first = (op_q == OP_B0);
		mac_ctl.neg   = (op_q == OP_A1A) || (op_q == OP_A1B) || (op_q == OP_A2);
		seq.op        = op_q;
		seq.busy      = (state_q != ST_IDLE);
		seq.wb        = 1'b0;
		seq.ld_out    = 1'b0;
		unique case (state_q)
			ST_IDLE: begin
				if (start) begin
					state_d = ST_RUN;
					op_d    = OP_B0;
					stage_d = '0;
				end
			end
			ST_RUN: begin
				mac_ctl.issue = 1'b1;
				if (op_q == OP_A2) begin
					state_d = ST_LAST;
				end else begin
					op_d = op_t'(op_q + 3'd1);
				end
			end
			ST_LAST: begin
				// final accumulate lands this cycle; write back history
				seq.wb = 1'b1;
				if (stage_q == last_stage) begin
					if (out_free) begin
						seq.ld_out = 1'b1;
						state_d    = ST_IDLE;
					end else begin
						state_d = ST_HOLD;
					end
				end else begin
					stage_d = stage_q + 1'b1;
					op_d    = OP_B0;
					state_d = ST_RUN;
				end
			end
			ST_HOLD: begin
				if (out_free) begin
					seq.ld_out = 1'b1;
					state_d    = ST_IDLE;
				end
			end
			default: begin
				state_d = ST_IDLE;
			end
		endcase
	end

	assign stage = stage_q;

	assert property (@(posedge clk) disable iff (!arst_n)
		seq.busy |-> stage_q <= last_stage)
		else $error("stage counter ran past the last active stage");

	assert property (@(posedge clk) disable iff (!arst_n)
		state_q == ST_LAST |-> $past(state_q == ST_RUN && op_q == OP_A2))
		else $error("writeback without a completed operation sequence");

endmodule
`default_nettype wire

/* hw/rtl/cascaded_biquad_iir_q15_unit.sv */
`default_nettype none
// ----------------------------------------------------------------------------
// Cascaded biquad IIR filter, Q15
// One to MAX_STAGES direct-form-I biquads run on one shared saturating MAC.
// ----------------------------------------------------------------------------
// The sequencer issues seven MAC steps and then writes back history for each active
// stage; in_stall stays high while it is busy, so a new sample is taken only after
// the last one is loaded into the output register, which a stalled output holds off.
// Reset clears filter history and sets three stages with zero coefficients.
module cascaded_biquad_iir_q15_unit
	import cbq_pkg::*;
#(
	parameter int MAX_STAGES = 3
)
(
	input  wire logic                         clk,
	input  wire logic                         arst_n,
	input  wire logic                         in_valid,
	output logic                              in_stall,
	input  wire logic signed [DATA_W-1:0]     sample_in,
	output logic                              out_valid,
	input  wire logic                         out_stall,
	output logic signed [DATA_W-1:0]          sample_out,
	input  wire logic                         cfg_wr_en,
	input  wire logic [CFG_IDX_W-1:0]         cfg_index,
	input  wire logic [CFG_DATA_W-1:0]        cfg_data
);

	localparam int SW    = (MAX_STAGES > 1) ? $clog2(MAX_STAGES) : 1;
	localparam int HD    = 4 * MAX_STAGES;
	localparam int HW    = $clog2(HD);

	logic [ACT_W-1:0]          act_q;
	logic [FWD_W-1:0]          fwd_q [MAX_STAGES];
	logic [FB_W-1:0]           fb_q [MAX_STAGES];
	logic signed [DATA_W-1:0]  hist_q [HD];
	logic signed [DATA_W-1:0]  x_q;
	logic signed [DATA_W-1:0]  x1_q;
	logic signed [DATA_W-1:0]  y1_q;
	logic                      out_valid_q;
	logic signed [DATA_W-1:0]  sample_out_q;

	logic [ACT_W-1:0]          act_eff;
	logic [SW-1:0]             last_stage;
	logic                      start;
	logic                      out_free;
	mac_ctl_t                  mac_ctl;
	seq_t                      seq;
	logic [SW-1:0]             stage;
	logic [FWD_W-1:0]          cur_fwd;
	logic [FB_W-1:0]           cur_fb;
	logic [1:0]                slot;
	logic                      use_hist;
	logic [HW-1:0]             rd_idx;
	logic signed [DATA_W-1:0]  coef;
	logic signed [DATA_W-1:0]  data;
	logic signed [ACC_W-1:0]   acc_next;
	logic signed [DATA_W-1:0]  y;

	assign start    = in_valid && !in_stall;
	assign in_stall = seq.busy;
	assign out_free = !out_valid_q || !out_stall;

	// clamp stage count to 1..MAX_STAGES
	always_comb begin
		act_eff = act_q;
		if (act_q == '0) begin
			act_eff = 2'd1;
		end else if (act_q > ACT_W'(MAX_STAGES)) begin
			act_eff = ACT_W'(MAX_STAGES);
		end
		last_stage = SW'(act_eff - 2'd1);
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			act_q <= ACT_W'(3);
			for (int k = 0; k < MAX_STAGES; k++) begin
				fwd_q[k] <= '0;
				fb_q[k]  <= '0;
			end
		end else if (cfg_wr_en) begin
			if (cfg_index == REG_ACTIVE) begin
				act_q <= cfg_data[ACT_W-1:0];
			end
			for (int k = 0; k < MAX_STAGES; k++) begin
				if (cfg_index == REG_S0_FWD + CFG_IDX_W'(2 * k)) begin
					fwd_q[k] <= cfg_data[FWD_W-1:0];
				end
				if (cfg_index == REG_S0_FB + CFG_IDX_W'(2 * k)) begin
					fb_q[k] <= cfg_data[FB_W-1:0];
				end
			end
		end
	end

	cbq_ctrl #(
		.SW(SW)
	) u_ctrl (
		.clk        (clk),
		.arst_n     (arst_n),
		.start      (start),
		.last_stage (last_stage),
		.out_free   (out_free),
		.mac_ctl    (mac_ctl),
		.seq        (seq),
		.stage      (stage)
	);

	assign cur_fwd = fwd_q[stage];
	assign cur_fb  = fb_q[stage];

	// operand select for the current MAC step
	always_comb begin
		coef     = cur_fwd[15:0];
		slot     = SLOT_X1;
		use_hist = 1'b0;
		case (seq.op) inside
			OP_B0: begin
				coef = cur_fwd[15:0];
			end
			OP_B1A, OP_B1B: begin
				coef     = cur_fwd[31:16];
				slot     = SLOT_X1;
				use_hist = 1'b1;
			end
			OP_B2: begin
				coef     = cur_fwd[47:32];
				slot     = SLOT_X2;
				use_hist = 1'b1;
			end
			OP_A1A, OP_A1B: begin
				coef     = cur_fb[15:0];
				slot     = SLOT_Y1;
				use_hist = 1'b1;
			end
			OP_A2: begin
				coef     = cur_fb[31:16];
				slot     = SLOT_Y2;
				use_hist = 1'b1;
			end
			default: begin
				coef = cur_fwd[15:0];
			end
		endcase
		rd_idx = HW'({stage, slot});
		data   = use_hist ? hist_q[rd_idx] : x_q;
	end

	cbq_mac u_mac (
		.clk      (clk),
		.arst_n   (arst_n),
		.ctl      (mac_ctl),
		.coef     (coef),
		.data     (data),
		.acc_next (acc_next)
	);

	assign y = acc_next[ACC_W-1:ACC_W-DATA_W];

	// hold stage input and the old delay values seen during the run
	always_ff @(posedge clk) begin
		if (start) begin
			x_q <= sample_in;
		end else if (seq.wb) begin
			x_q <= y;
		end
		if (mac_ctl.issue && seq.op == OP_B1A) begin
			x1_q <= data;
		end
		if (mac_ctl.issue && seq.op == OP_A1A) begin
			y1_q <= data;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int i = 0; i < HD; i++) begin
				hist_q[i] <= '0;
			end
		end else if (seq.wb) begin
			for (int i = 0; i < HD; i++) begin
				if (stage == SW'(i >> 2)) begin
					case (2'(i))
						SLOT_X1: hist_q[i] <= x_q;
						SLOT_X2: hist_q[i] <= x1_q;
						SLOT_Y1: hist_q[i] <= y;
						default: hist_q[i] <= y1_q;
					endcase
				end
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (seq.ld_out) begin
			out_valid_q <= 1'b1;
		end else if (!out_stall) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (seq.ld_out) begin
			sample_out_q <= seq.wb ? y : x_q;
		end
	end

	assign out_valid  = out_valid_q;
	assign sample_out = sample_out_q;

	assert property (@(posedge clk) disable iff (!arst_n)
		start |=> in_stall)
		else $error("request accepted while the previous sample was still running");

	assert property (@(posedge clk) disable iff (!arst_n)
		seq.ld_out |-> out_free)
		else $error("result loaded over an unaccepted output");

endmodule
`default_nettype wire

/* test/biquad_scoreboard_pkg.sv */
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// Biquad cascade scoreboard
// Keeps its own copy of the coefficient registers and the per-stage history,
// works out the filtered sample for every accepted request and checks each
// returned sample against the oldest one still outstanding.
// ----------------------------------------------------------------------------
package biquad_scoreboard_pkg;
	import cbq_pkg::*;

	localparam int STAGE_LIMIT = 3;

	localparam logic [CFG_IDX_W-1:0] REG_S1_FWD = 3'd3;
	localparam logic [CFG_IDX_W-1:0] REG_S1_FB  = 3'd4;
	localparam logic [CFG_IDX_W-1:0] REG_S2_FWD = 3'd5;
	localparam logic [CFG_IDX_W-1:0] REG_S2_FB  = 3'd6;
	localparam logic [CFG_IDX_W-1:0] REG_SPARE  = 3'd7;

	localparam longint ACC_MAX = 64'sd2147483647;
	localparam longint ACC_MIN = -64'sd2147483648;

	class biquad_scoreboard;
		logic [ACT_W-1:0]          stage_count;
		logic [FWD_W-1:0]          fwd_coef [STAGE_LIMIT];
		logic [FB_W-1:0]           fb_coef [STAGE_LIMIT];
		logic signed [DATA_W-1:0]  x_hist [2*STAGE_LIMIT];
		logic signed [DATA_W-1:0]  y_hist [2*STAGE_LIMIT];
		logic signed [DATA_W-1:0]  filtered_q [$];
		int                        errors;

		function new();
			stage_count = 2'd3;
			errors = 0;
			for (int k = 0; k < STAGE_LIMIT; k++) begin
				fwd_coef[k] = '0;
				fb_coef[k] = '0;
			end
			for (int i = 0; i < 2*STAGE_LIMIT; i++) begin
				x_hist[i] = '0;
				y_hist[i] = '0;
			end
		endfunction

		function void write_reg(logic [CFG_IDX_W-1:0] idx, logic [CFG_DATA_W-1:0] data);
			case (idx)
				REG_ACTIVE: stage_count = data[ACT_W-1:0];
				REG_S0_FWD: fwd_coef[0] = data[FWD_W-1:0];
				REG_S0_FB:  fb_coef[0] = data[FB_W-1:0];
				REG_S1_FWD: fwd_coef[1] = data[FWD_W-1:0];
				REG_S1_FB:  fb_coef[1] = data[FB_W-1:0];
				REG_S2_FWD: fwd_coef[2] = data[FWD_W-1:0];
				REG_S2_FB:  fb_coef[2] = data[FB_W-1:0];
				default: ;
			endcase
		endfunction

		function logic signed [ACC_W-1:0] clip(longint v);
			if (v > ACC_MAX)
				return ACC_W'(ACC_MAX);
			if (v < ACC_MIN)
				return ACC_W'(ACC_MIN);
			return ACC_W'(v);
		endfunction

		// doubled product saturates first, then the sum or difference
		function logic signed [ACC_W-1:0] mac_step(logic signed [ACC_W-1:0] acc,
				logic signed [DATA_W-1:0] a, logic signed [DATA_W-1:0] b, bit neg);
			longint prod;
			prod = longint'(clip(longint'(a) * longint'(b) * 2));
			return clip(neg ? longint'(acc) - prod : longint'(acc) + prod);
		endfunction

		function logic signed [DATA_W-1:0] filter_stage(int k, logic signed [DATA_W-1:0] x);
			logic signed [DATA_W-1:0] b0, b1h, b2, a1h, a2, y;
			logic signed [ACC_W-1:0]  acc;
			b0  = fwd_coef[k][15:0];
			b1h = fwd_coef[k][31:16];
			b2  = fwd_coef[k][47:32];
			a1h = fb_coef[k][15:0];
			a2  = fb_coef[k][31:16];
			acc = '0;
			acc = mac_step(acc, b0, x, 1'b0);
			acc = mac_step(acc, b1h, x_hist[2*k], 1'b0);
			acc = mac_step(acc, b1h, x_hist[2*k], 1'b0);
			acc = mac_step(acc, b2, x_hist[2*k+1], 1'b0);
			acc = mac_step(acc, a1h, y_hist[2*k], 1'b1);
			acc = mac_step(acc, a1h, y_hist[2*k], 1'b1);
			acc = mac_step(acc, a2, y_hist[2*k+1], 1'b1);
			y = acc[ACC_W-1:16];
			y_hist[2*k+1] = y_hist[2*k];
			y_hist[2*k]   = y;
			x_hist[2*k+1] = x_hist[2*k];
			x_hist[2*k]   = x;
			return y;
		endfunction

		function void note_request(logic signed [DATA_W-1:0] sample);
			int n;
			logic signed [DATA_W-1:0] v;
			n = int'(stage_count);
			// a count of zero runs one stage
			if (n < 1)
				n = 1;
			if (n > STAGE_LIMIT)
				n = STAGE_LIMIT;
			v = sample;
			for (int k = 0; k < n; k++)
				v = filter_stage(k, v);
			filtered_q.push_back(v);
		endfunction

		function void check_result(logic signed [DATA_W-1:0] got);
			logic signed [DATA_W-1:0] want;
			if (filtered_q.size() == 0) begin
				$error("sample_out: no request outstanding, actual %0d", got);
				errors++;
				return;
			end
			want = filtered_q.pop_front();
			if (got !== want) begin
				$error("sample_out mismatch: expected %0d, actual %0d", want, got);
				errors++;
			end
		endfunction

		function int pending();
			return filtered_q.size();
		endfunction
	endclass

endpackage

/* test/tb_top.sv */
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// Cascaded biquad filter testbench
// Drives samples through the filter under a sequence of coefficient and
// stage-count settings, directed corner cases first and then random traffic,
// with random gaps on the input, random stalls on the output, and checks every output sample.
// ----------------------------------------------------------------------------
module tb_top;
	import cbq_pkg::*;
	import biquad_scoreboard_pkg::*;

	localparam int RANDOM_REQUESTS = 850;
	localparam int CYCLE_LIMIT     = 500000;

	typedef enum int {
		COEF_FULL,
		COEF_SMALL,
		COEF_EDGE,
		COEF_MIXED
	} coef_style_t;

	logic                      clk;
	logic                      arst_n;
	logic                      in_valid;
	logic                      in_stall;
	logic signed [DATA_W-1:0]  sample_in;
	logic                      out_valid;
	logic                      out_stall;
	logic signed [DATA_W-1:0]  sample_out;
	logic                      cfg_wr_en;
	logic [CFG_IDX_W-1:0]      cfg_index;
	logic [CFG_DATA_W-1:0]     cfg_data;

	biquad_scoreboard board;
	bit                calm = 1'b0;
	int unsigned       cycle_count = 0;

	cascaded_biquad_iir_q15_unit u_dut (
		.clk        (clk),
		.arst_n     (arst_n),
		.in_valid   (in_valid),
		.in_stall   (in_stall),
		.sample_in  (sample_in),
		.out_valid  (out_valid),
		.out_stall  (out_stall),
		.sample_out (sample_out),
		.cfg_wr_en  (cfg_wr_en),
		.cfg_index  (cfg_index),
		.cfg_data   (cfg_data)
	);

	initial clk = 1'b0;
	always #10 clk = ~clk;

	always @(posedge clk) begin
		cycle_count <= cycle_count + 1;
		if (cycle_count >= CYCLE_LIMIT) begin
			$display("CHECKS FAILED");
			$finish;
		end
	end

	always @(posedge clk) begin
		if (arst_n && out_valid && !out_stall)
			board.check_result(sample_out);
	end

	// output back-pressure: free runs, some long, then stall bursts
	initial begin
		forever begin
			out_stall <= 1'b0;
			repeat ($urandom_range(1, ($urandom_range(0, 3) == 0) ? 60 : 12)) @(posedge clk);
			if (!calm) begin
				out_stall <= 1'b1;
				repeat ($urandom_range(1, 17)) @(posedge clk);
			end
		end
	end

	function automatic logic [47:0] rand48();
		return 48'({$urandom, $urandom});
	endfunction

	function automatic logic [15:0] pick_coef(coef_style_t style);
		coef_style_t s;
		s = style;
		if (s == COEF_MIXED)
			s = coef_style_t'($urandom_range(0, 2));
		case (s)
			COEF_SMALL: return 16'($urandom_range(0, 8191) - 4096);
			COEF_EDGE: begin
				case ($urandom_range(0, 3))
					0: return 16'h8000;
					1: return 16'h7FFF;
					2: return 16'h0000;
					default: return 16'hFFFF;
				endcase
			end
			default: return 16'($urandom);
		endcase
	endfunction

	function automatic logic [15:0] pick_sample();
		case ($urandom_range(0, 11))
			0: return 16'h8000;
			1: return 16'h7FFF;
			2: return 16'h0000;
			3, 4: return 16'($urandom_range(0, 511) - 256);
			default: return 16'($urandom);
		endcase
	endfunction

	task automatic send_sample(input logic [DATA_W-1:0] s);
		int gap;
		gap = 0;
		if (!calm && $urandom_range(0, 3) == 0)
			gap = $urandom_range(1, 17);
		if (gap > 0) begin
			in_valid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
		in_valid  <= 1'b1;
		sample_in <= s;
		@(posedge clk);
		while (in_stall)
			@(posedge clk);
		board.note_request(s);
	endtask

	// hold off new requests until every outstanding sample has returned
	task automatic drain();
		in_valid <= 1'b0;
		while (board.pending() != 0)
			@(posedge clk);
		repeat (4) @(posedge clk);
	endtask

	task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [CFG_DATA_W-1:0] data);
		cfg_wr_en <= 1'b1;
		cfg_index <= idx;
		cfg_data  <= data;
		@(posedge clk);
		cfg_wr_en <= 1'b0;
		@(posedge clk);
		board.write_reg(idx, data);
	endtask

	// unused upper bits of the narrow registers carry random junk
	task automatic load_filter(input logic [ACT_W-1:0] act,
			input logic [FWD_W-1:0] f0, input logic [FB_W-1:0] g0,
			input logic [FWD_W-1:0] f1, input logic [FB_W-1:0] g1,
			input logic [FWD_W-1:0] f2, input logic [FB_W-1:0] g2);
		logic [47:0] pad;
		drain();
		pad = rand48();
		write_reg(REG_ACTIVE, {pad[47:2], act});
		write_reg(REG_S0_FWD, f0);
		pad = rand48();
		write_reg(REG_S0_FB, {pad[47:32], g0});
		write_reg(REG_S1_FWD, f1);
		pad = rand48();
		write_reg(REG_S1_FB, {pad[47:32], g1});
		write_reg(REG_S2_FWD, f2);
		pad = rand48();
		write_reg(REG_S2_FB, {pad[47:32], g2});
	endtask

	task automatic random_filter(input coef_style_t style);
		logic [FWD_W-1:0] f [3];
		logic [FB_W-1:0]  g [3];
		for (int k = 0; k < 3; k++) begin
			f[k] = {pick_coef(style), pick_coef(style), pick_coef(style)};
			g[k] = {pick_coef(style), pick_coef(style)};
		end
		load_filter(ACT_W'($urandom_range(0, 3)), f[0], g[0], f[1], g[1], f[2], g[2]);
	endtask

	initial begin
		int remaining;
		int chunk;
		board = new();
		in_valid  = 1'b0;
		sample_in = '0;
		cfg_wr_en = 1'b0;
		cfg_index = '0;
		cfg_data  = '0;
		arst_n    = 1'b0;
		repeat (3) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// reset settings: three stages, all coefficients zero
		send_sample(16'h7FFF);
		send_sample(16'h8000);

		// one stage, b0 at minus full scale: full-scale product saturates
		load_filter(2'd1, 48'h0000_0000_8000, 32'h0, 48'h0, 32'h0, 48'h0, 32'h0);
		send_sample(16'h8000);
		send_sample(16'h7FFF);
		send_sample(16'h0000);

		// zero stages runs one; negative feedback words drive it to the rail
		load_filter(2'd0, 48'h7FFF_7FFF_7FFF, 32'h8000_8000,
			48'hFFFF_FFFF_FFFF, 32'hFFFF_FFFF, 48'h0, 32'h0);
		write_reg(REG_SPARE, rand48());
		send_sample(16'h7FFF);
		send_sample(16'h7FFF);
		send_sample(16'h8000);
		send_sample(16'h5555);
		send_sample(16'hAAAA);
		send_sample(16'h0001);

		load_filter(2'd2, 48'h4000_2000_4000, 32'hC000_2000,
			48'hFFFF_FFFF_FFFF, 32'h7FFF_7FFF, 48'h0, 32'h0);
		send_sample(16'hFFFF);
		send_sample(16'h7FFF);
		send_sample(16'h8000);
		send_sample(16'h1234);

		load_filter(2'd3, 48'h7FFF_8000_7FFF, 32'h7FFF_8000,
			48'hFFFF_FFFF_FFFF, 32'hFFFF_FFFF, 48'h8000_7FFF_8000, 32'h8000_7FFF);
		send_sample(16'h8000);
		send_sample(16'h7FFF);
		send_sample(16'h8000);
		send_sample(16'h7FFF);
		send_sample(16'h0000);
		send_sample(16'h00FF);
		send_sample(16'hFF00);

		remaining = RANDOM_REQUESTS;
		while (remaining > 0) begin
			chunk = $urandom_range(60, 140);
			if (remaining <= 140) begin
				chunk = remaining;
				calm = 1'b1;
			end
			random_filter(coef_style_t'($urandom_range(0, 3)));
			for (int i = 0; i < chunk; i++) begin
				send_sample(pick_sample());
				if (!calm && $urandom_range(0, 49) == 0)
					drain();
			end
			remaining -= chunk;
		end

		drain();
		repeat (50) @(posedge clk);
		if (board.errors == 0)
			$display("ALL CHECKS PASSED");
		else
			$display("CHECKS FAILED");
		$finish;
	end

endmodule
